// ----- sv/bsr_pkg.sv -----
// Shared constants, command codes and inter-module structs of the bounding sphere radius block.
`default_nettype none
package bsr_pkg;

   localparam int VERTEX_DEPTH  = 1024;
   localparam int FRACTION_BITS = 16;

   localparam int WORD_W   = 32;
   localparam int ADDR_W   = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
   localparam int COUNT_W  = $clog2(VERTEX_DEPTH + 1);
   localparam int CENTER_W = WORD_W + 1;
   localparam int VERTEX_W = 3 * WORD_W;
   localparam int SQ_W     = 2 * WORD_W;
   localparam int RADIUS_W = WORD_W + 1;
   localparam int ROWS     = 3;
   localparam int ROW_TERMS = 4;
   localparam int COEF_COUNT = ROWS * ROW_TERMS;

   localparam logic [1:0] CMD_LOAD_ROW   = 2'd0;
   localparam logic [1:0] CMD_ADD_VERTEX = 2'd1;
   localparam logic [1:0] CMD_FINISH     = 2'd2;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic signed [WORD_W-1:0] FIX_ONE  = WORD_W'(1) << FRACTION_BITS;

   typedef struct packed {
      logic                     valid;
      logic [1:0]               axis;
      logic signed [WORD_W-1:0] coef_a;
      logic signed [WORD_W-1:0] coef_b;
      logic signed [WORD_W-1:0] coef_c;
      logic signed [WORD_W-1:0] coef_d;
      logic signed [WORD_W-1:0] vx;
      logic signed [WORD_W-1:0] vy;
      logic signed [WORD_W-1:0] vz;
   } xform_in_type;

   typedef struct packed {
      logic                     valid;
      logic [1:0]               axis;
      logic signed [WORD_W-1:0] value;
   } xform_out_type;

   typedef struct packed {
      logic                en;
      logic [ADDR_W-1:0]   addr;
      logic [VERTEX_W-1:0] data;
   } store_wr_type;

   typedef struct packed {
      logic                       start;
      logic [COUNT_W-1:0]         length;
      logic signed [CENTER_W-1:0] cx;
      logic signed [CENTER_W-1:0] cy;
      logic signed [CENTER_W-1:0] cz;
   } walk_cmd_type;

endpackage
`default_nettype wire

// ----- sv/bounding_sphere_radius.sv -----
// Top level: command sequencer, transform rows, box tracking and the result register.
// A row load is written straight into the row registers; an added vertex sends three axes
// through the three-stage multiply pipeline, then one store write, before the next transfer.
// A finish walks the N stored vertices, one store read per cycle through a four-stage
// distance pipeline, then runs the iterative square root. One command is in work at a time;
// a result in the output register does not stall requests, but one held back from it does.
// Reset loads the identity transform and empties the set; the store gets no clearing pass.
`default_nettype none
module bounding_sphere_radius (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_command,
   input  logic [1:0]                          req_row_index,
   input  logic signed [bsr_pkg::WORD_W-1:0]   req_operand_a,
   input  logic signed [bsr_pkg::WORD_W-1:0]   req_operand_b,
   input  logic signed [bsr_pkg::WORD_W-1:0]   req_operand_c,
   input  logic signed [bsr_pkg::WORD_W-1:0]   req_operand_d,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bsr_pkg::RADIUS_W-1:0]        rsp_radius,
   output logic                                rsp_empty_set,
   output logic                                rsp_dropped_vertices
);
   import bsr_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_XFORM = 3'd1;
   localparam logic [2:0] ST_WALK  = 3'd2;
   localparam logic [2:0] ST_SQRT  = 3'd3;
   localparam logic [2:0] ST_HOLD  = 3'd4;

   logic [2:0]                 state_ff;
   logic [1:0]                 iss_ff;
   logic signed [WORD_W-1:0]   rows_ff [COEF_COUNT];
   logic signed [WORD_W-1:0]   vtx_ff [3];
   logic signed [WORD_W-1:0]   w_ff [2];
   logic signed [WORD_W-1:0]   box_min_ff [3];
   logic signed [WORD_W-1:0]   box_max_ff [3];
   logic [COUNT_W-1:0]         count_ff;
   logic                       overflow_ff;
   logic signed [CENTER_W-1:0] center_ff [3];
   logic [COUNT_W-1:0]         walk_len_ff;
   logic                       empty_ff;
   logic                       dropped_ff;
   logic                       walk_start_ff;
   logic                       sqrt_start_ff;
   logic                       rsp_valid_ff;
   logic [RADIUS_W-1:0]        rsp_radius_ff;
   logic                       rsp_empty_ff;
   logic                       rsp_dropped_ff;

   logic                       accept;
   logic                       rsp_free;
   logic                       rsp_load;
   logic signed [CENTER_W-1:0] center_in [3];
   xform_in_type               xin;
   xform_out_type              xout;
   store_wr_type               wr;
   walk_cmd_type               wcmd;
   logic                       walk_done;
   logic [SQ_W-1:0]            walk_best;
   logic                       sqrt_done;
   logic [RADIUS_W-1:0]        sqrt_root;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   // A new result goes into the output register in this cycle.
   assign rsp_load  = (((state_ff == ST_SQRT) && sqrt_done) || (state_ff == ST_HOLD))
                      && rsp_free;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         center_in[i] = (CENTER_W'(box_min_ff[i]) + CENTER_W'(box_max_ff[i])) >>> 1;
      end
   end

   always_comb begin
      xin.valid  = (state_ff == ST_XFORM) && (iss_ff <= AXIS_Z);
      xin.axis   = iss_ff;
      xin.coef_a = rows_ff[{iss_ff, 2'd0}];
      xin.coef_b = rows_ff[{iss_ff, 2'd1}];
      xin.coef_c = rows_ff[{iss_ff, 2'd2}];
      xin.coef_d = rows_ff[{iss_ff, 2'd3}];
      xin.vx     = vtx_ff[0];
      xin.vy     = vtx_ff[1];
      xin.vz     = vtx_ff[2];
   end

   // The last axis goes into the store together with the two held ones.
   always_comb begin
      wr.en   = xout.valid && (xout.axis == AXIS_Z);
      wr.addr = count_ff[ADDR_W-1:0];
      wr.data = {xout.value, w_ff[1], w_ff[0]};
   end

   always_comb begin
      wcmd.start  = walk_start_ff;
      wcmd.length = walk_len_ff;
      wcmd.cx     = center_ff[0];
      wcmd.cy     = center_ff[1];
      wcmd.cz     = center_ff[2];
   end

   bsr_xform u_xform (
      .clock (clock),
      .reset (reset),
      .xin   (xin),
      .xout  (xout)
   );

   bsr_walk u_walk (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .cmd   (wcmd),
      .done  (walk_done),
      .best  (walk_best)
   );

   bsr_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start_ff),
      .value (walk_best),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         iss_ff        <= AXIS_X;
         count_ff      <= '0;
         overflow_ff   <= 1'b0;
         walk_start_ff <= 1'b0;
         sqrt_start_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < COEF_COUNT; i++) begin
            rows_ff[i] <= '0;
         end
         for (int r = 0; r < ROWS; r++) begin
            rows_ff[ROW_TERMS*r + r] <= FIX_ONE;
         end
         for (int i = 0; i < 3; i++) begin
            box_min_ff[i] <= WORD_MAX;
            box_max_ff[i] <= WORD_MIN;
         end
      end else begin
         walk_start_ff <= 1'b0;
         sqrt_start_ff <= 1'b0;
         if (rsp_valid_ff && !rsp_stall && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff) inside
            ST_IDLE: begin
               if (accept) begin
                  unique case (req_command)
                     CMD_LOAD_ROW: begin
                        for (int r = 0; r < ROWS; r++) begin
                           if (req_row_index == 2'(r)) begin
                              rows_ff[ROW_TERMS*r + 0] <= req_operand_a;
                              rows_ff[ROW_TERMS*r + 1] <= req_operand_b;
                              rows_ff[ROW_TERMS*r + 2] <= req_operand_c;
                              rows_ff[ROW_TERMS*r + 3] <= req_operand_d;
                           end
                        end
                     end
                     CMD_ADD_VERTEX: begin
                        if (count_ff == COUNT_W'(VERTEX_DEPTH)) begin
                           overflow_ff <= 1'b1;
                        end else begin
                           vtx_ff[0] <= req_operand_a;
                           vtx_ff[1] <= req_operand_b;
                           vtx_ff[2] <= req_operand_c;
                           iss_ff    <= AXIS_X;
                           state_ff  <= ST_XFORM;
                        end
                     end
                     CMD_FINISH: begin
                        for (int i = 0; i < 3; i++) begin
                           center_ff[i]  <= center_in[i];
                           box_min_ff[i] <= WORD_MAX;
                           box_max_ff[i] <= WORD_MIN;
                        end
                        walk_len_ff   <= count_ff;
                        empty_ff      <= (count_ff == '0);
                        dropped_ff    <= overflow_ff;
                        count_ff      <= '0;
                        overflow_ff   <= 1'b0;
                        walk_start_ff <= 1'b1;
                        state_ff      <= ST_WALK;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_XFORM: begin
               if (xin.valid) begin
                  iss_ff <= iss_ff + 2'd1;
               end
               if (xout.valid) begin
                  if (xout.axis != AXIS_Z) begin
                     w_ff[xout.axis[0]] <= xout.value;
                  end
                  if (xout.value < box_min_ff[xout.axis]) begin
                     box_min_ff[xout.axis] <= xout.value;
                  end
                  if (xout.value > box_max_ff[xout.axis]) begin
                     box_max_ff[xout.axis] <= xout.value;
                  end
                  if (xout.axis == AXIS_Z) begin
                     count_ff <= count_ff + COUNT_W'(1);
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_WALK: begin
               if (walk_done) begin
                  sqrt_start_ff <= 1'b1;
                  state_ff      <= ST_SQRT;
               end
            end
            ST_SQRT, ST_HOLD: begin
               if (sqrt_done || (state_ff == ST_HOLD)) begin
                  if (rsp_free) begin
                     rsp_valid_ff   <= 1'b1;
                     rsp_radius_ff  <= sqrt_root;
                     rsp_empty_ff   <= empty_ff;
                     rsp_dropped_ff <= dropped_ff;
                     state_ff       <= ST_IDLE;
                  end else begin
                     state_ff <= ST_HOLD;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_radius           = rsp_radius_ff;
   assign rsp_empty_set        = rsp_empty_ff;
   assign rsp_dropped_vertices = rsp_dropped_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(VERTEX_DEPTH))
      else $error("vertex count passed the store depth");

   a_xform_in_state: assert property (@(posedge clock) disable iff (reset)
      xout.valid |-> (state_ff == ST_XFORM))
      else $error("transform result outside of a vertex transfer");

   a_walk_done_state: assert property (@(posedge clock) disable iff (reset)
      walk_done |-> (state_ff == ST_WALK))
      else $error("walk finished outside of the walk phase");

   a_sqrt_done_state: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> (state_ff == ST_SQRT))
      else $error("square root finished outside of its phase");

   a_store_write_clean: assert property (@(posedge clock) disable iff (reset)
      wr.en |=> (count_ff == $past(count_ff) + COUNT_W'(1)) && (state_ff == ST_IDLE))
      else $error("store write did not advance the vertex count");

endmodule
`default_nettype wire

// ----- sv/bsr_xform.sv -----
// Three-stage affine transform pipeline that produces one saturated output axis per issue.
`default_nettype none
module bsr_xform (
   input  logic                   clock,
   input  logic                   reset,
   input  bsr_pkg::xform_in_type  xin,
   output bsr_pkg::xform_out_type xout
);
   import bsr_pkg::*;

   localparam int PROD_W = 2 * WORD_W;
   localparam int SUM_W  = PROD_W + 2;

   logic                     v1_ff;
   logic [1:0]               axis1_ff;
   logic signed [PROD_W-1:0] prod_ff [3];
   logic signed [WORD_W-1:0] d1_ff;

   logic                     v2_ff;
   logic [1:0]               axis2_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [WORD_W-1:0] d2_ff;

   logic                     v3_ff;
   logic [1:0]               axis3_ff;
   logic signed [WORD_W-1:0] value_ff;

   logic signed [PROD_W-1:0] prod_in [3];
   logic signed [SUM_W-1:0]  total;
   logic signed [WORD_W-1:0] value_in;

   always_comb begin
      prod_in[0] = xin.coef_a * xin.vx;
      prod_in[1] = xin.coef_b * xin.vy;
      prod_in[2] = xin.coef_c * xin.vz;
   end

   // Flooring the exact sum once equals flooring each product and carrying the low parts.
   always_comb begin
      total = (sum_ff >>> FRACTION_BITS) + SUM_W'(d2_ff);
      if (&total[SUM_W-1:WORD_W-1] || ~|total[SUM_W-1:WORD_W-1]) begin
         value_in = total[WORD_W-1:0];
      end else if (total[SUM_W-1]) begin
         value_in = WORD_MIN;
      end else begin
         value_in = WORD_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= xin.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      prod_ff[0] <= prod_in[0];
      prod_ff[1] <= prod_in[1];
      prod_ff[2] <= prod_in[2];
      d1_ff      <= xin.coef_d;
      axis1_ff   <= xin.axis;
      sum_ff     <= SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2]);
      d2_ff      <= d1_ff;
      axis2_ff   <= axis1_ff;
      value_ff   <= value_in;
      axis3_ff   <= axis2_ff;
   end

   assign xout.valid = v3_ff;
   assign xout.axis  = axis3_ff;
   assign xout.value = value_ff;

endmodule
`default_nettype wire

// ----- sv/bsr_walk.sv -----
// World vertex store and the pipelined walk that finds the largest squared distance to the center.
`default_nettype none
module bsr_walk (
   input  logic                  clock,
   input  logic                  reset,
   input  bsr_pkg::store_wr_type wr,
   input  bsr_pkg::walk_cmd_type cmd,
   output logic                  done,
   output logic [2*bsr_pkg::WORD_W-1:0] best
);
   import bsr_pkg::*;

   logic [VERTEX_W-1:0] mem [VERTEX_DEPTH];
   logic [VERTEX_W-1:0] rd_data_ff;

   logic               active_ff;
   logic [COUNT_W-1:0] issue_ff;
   logic [COUNT_W-1:0] length_ff;
   logic               rd_valid_ff;
   logic               mag_valid_ff;
   logic               sq_valid_ff;
   logic               sum_valid_ff;
   logic               done_ff;

   logic [WORD_W-1:0]  mag_ff [3];
   logic [SQ_W-1:0]    sq_ff [3];
   logic [SQ_W-1:0]    sum_ff;
   logic [SQ_W-1:0]    best_ff;

   logic                       issue;
   logic signed [CENTER_W-1:0] center [3];
   logic signed [CENTER_W:0]   diff [3];
   logic [WORD_W-1:0]          mag_in [3];

   assign issue = active_ff && (issue_ff != length_ff);

   // Writes and the walk never overlap: the walk starts only after the last vertex is stored.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= mem[issue_ff[ADDR_W-1:0]];
      end
   end

   assign center[0] = cmd.cx;
   assign center[1] = cmd.cy;
   assign center[2] = cmd.cz;

   // The distance to the floor center never exceeds half the box span rounded up, so it fits one word.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i] = (CENTER_W+1)'(signed'(rd_data_ff[WORD_W*i +: WORD_W]))
                 - (CENTER_W+1)'(center[i]);
         mag_in[i] = diff[i][CENTER_W] ? WORD_W'(-diff[i]) : WORD_W'(diff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rd_valid_ff  <= 1'b0;
         mag_valid_ff <= 1'b0;
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         rd_valid_ff  <= issue;
         mag_valid_ff <= rd_valid_ff;
         sq_valid_ff  <= mag_valid_ff;
         sum_valid_ff <= sq_valid_ff;
         done_ff      <= 1'b0;
         if (cmd.start) begin
            active_ff <= 1'b1;
            issue_ff  <= '0;
            length_ff <= cmd.length;
            best_ff   <= '0;
         end else if (active_ff) begin
            if (issue) begin
               issue_ff <= issue_ff + COUNT_W'(1);
            end else if (!rd_valid_ff && !mag_valid_ff && !sq_valid_ff && !sum_valid_ff) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end
            if (sum_valid_ff && (sum_ff > best_ff)) begin
               best_ff <= sum_ff;
            end
         end
      end
      for (int i = 0; i < 3; i++) begin
         mag_ff[i] <= mag_in[i];
         sq_ff[i]  <= SQ_W'(mag_ff[i]) * SQ_W'(mag_ff[i]);
      end
      sum_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   assign done = done_ff;
   assign best = best_ff;

endmodule
`default_nettype wire

// ----- sv/bsr_isqrt.sv -----
// Iterative floor square root of a 64-bit value, one result bit per cycle.
`default_nettype none
module bsr_isqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [2*bsr_pkg::WORD_W-1:0]   value,
   output logic                           done,
   output logic [bsr_pkg::RADIUS_W-1:0]   root
);
   import bsr_pkg::*;

   logic [SQ_W-1:0] n_ff;
   logic [SQ_W-1:0] res_ff;
   logic [SQ_W-1:0] bit_ff;
   logic            busy_ff;
   logic            done_ff;

   logic [SQ_W:0]   trial;

   assign trial = (SQ_W+1)'(res_ff) + (SQ_W+1)'(bit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            n_ff    <= value;
            res_ff  <= '0;
            bit_ff  <= SQ_W'(1) << (SQ_W - 2);
         end else if (busy_ff) begin
            if ((SQ_W+1)'(n_ff) >= trial) begin
               n_ff   <= n_ff - trial[SQ_W-1:0];
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            if (bit_ff == SQ_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = res_ff[RADIUS_W-1:0];

endmodule
`default_nettype wire
